// ===== rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

    // Counter width and saturation value
    localparam int          CNT_W   = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Active-low button levels
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0]  REG_SHORT_MAX = 2'd1;
    localparam logic [1:0]  REG_LONG_MIN  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] DEBOUNCE_RST  = 16'd15;
    localparam logic [15:0] SHORT_MAX_RST = 16'd500;
    localparam logic [15:0] LONG_MIN_RST  = 16'd2000;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ms;
        logic [CNT_W-1:0] short_max_ms;
        logic [CNT_W-1:0] long_min_ms;
    } bdpc_cfg_t;

    typedef struct packed {
        logic             filtered_sample;
        logic             stable_level;
        logic             debounce_active;
        logic [CNT_W-1:0] debounce_count;
        logic [CNT_W-1:0] press_count;
        logic             long_armed;
    } bdpc_state_t;

    typedef struct packed {
        logic stable_out;
        logic press_event;
        logic release_event;
        logic short_event;
        logic long_event;
    } bdpc_result_t;

    // Increment that sticks at the top of the range
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/bdpc_step.sv =====
// One debounce and classification step: next state and result word from one sample.
module bdpc_step (
    input  bdpc_pkg::bdpc_state_t  state,
    input  bdpc_pkg::bdpc_cfg_t    cfg,
    input  logic                   pin_level,
    input  logic                   ms_tick,
    output bdpc_pkg::bdpc_state_t  state_next,
    output bdpc_pkg::bdpc_result_t result
);
    import bdpc_pkg::*;

    logic [CNT_W-1:0] deb_tick;
    logic [CNT_W-1:0] press_tick;
    logic             raw_change;
    logic             pend_active;
    logic [CNT_W-1:0] deb_cnt;
    logic             commit;
    logic             new_stable;
    logic             lvl_change;
    logic             ev_press;
    logic             ev_release;
    logic             ev_short;
    logic             ev_long;
    logic             armed;
    logic [CNT_W-1:0] press_cnt;

    always_comb
    begin
        // counters advance on a tick
        deb_tick   = ms_tick ? sat_inc(state.debounce_count) : state.debounce_count;
        press_tick = ms_tick ? sat_inc(state.press_count) : state.press_count;

        // a raw change restarts the debounce window
        raw_change  = (pin_level != state.filtered_sample);
        pend_active = state.debounce_active | raw_change;
        deb_cnt     = raw_change ? '0 : deb_tick;

        // commit once the window is long enough
        commit     = pend_active && (deb_cnt >= cfg.debounce_ms);
        new_stable = commit ? pin_level : state.stable_level;

        // events from a change of the stable level
        lvl_change = (new_stable != state.stable_level);
        ev_press   = lvl_change && (new_stable == LVL_PRESSED);
        ev_release = lvl_change && (new_stable == LVL_RELEASED);
        ev_short   = ev_release && (press_tick <= cfg.short_max_ms);
        press_cnt  = ev_press ? '0 : press_tick;

        armed = state.long_armed;
        if (ev_press)
        begin
            armed = 1'b1;
        end
        else if (ev_release)
        begin
            armed = 1'b0;
        end

        // long press fires once
        ev_long = armed && (press_cnt >= cfg.long_min_ms);

        state_next.filtered_sample = pin_level;
        state_next.stable_level    = new_stable;
        state_next.debounce_active = pend_active & ~commit;
        state_next.debounce_count  = deb_cnt;
        state_next.press_count     = press_cnt;
        state_next.long_armed      = armed & ~ev_long;

        result.stable_out    = new_stable;
        result.press_event   = ev_press;
        result.release_event = ev_release;
        result.short_event   = ev_short;
        result.long_event    = ev_long;
    end

endmodule

// ===== rtl/button_debounce_press_classifier_unit.sv =====
// Top level of the button debounce and press classifier.
//
// Input channel: in_valid / in_stall carry one word of pin_level (raw active-low
// sample) and ms_tick (one millisecond passed since the previous word).
// Output channel: out_valid / out_stall carry one result word per input word:
// the debounced level and the press, release, short and long events.
// Config port: cfg_we writes cfg_data into register cfg_index (0 debounce,
// 1 short max, 2 long min); other indexes are ignored. Write only when idle.
// The input register, then the result register, lie between an accepted input
// word and out_valid. Throughput: one word per cycle while the receiver does
// not stall, set by the state update that sits between the input register and
// the result register.
// Reset clears the pipeline, sets the level to released, clears the counters
// and loads the default register values.
// When the receiver stalls, the result register holds; one more word can
// wait in the input register, after which in_stall is raised.
module button_debounce_press_classifier_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdpc_pkg::CNT_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           pin_level,
    input  logic                           ms_tick,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           stable_out,
    output logic                           press_event,
    output logic                           release_event,
    output logic                           short_event,
    output logic                           long_event
);
    import bdpc_pkg::*;

    bdpc_cfg_t    cfg_reg;
    bdpc_state_t  state_reg;
    bdpc_state_t  state_next;
    bdpc_result_t result_next;
    bdpc_result_t out_reg;
    logic         out_valid_reg;
    logic         s1_valid_reg;
    logic         s1_pin_reg;
    logic         s1_tick_reg;
    logic         s1_advance;
    logic         in_accept;

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms  <= DEBOUNCE_RST;
            cfg_reg.short_max_ms <= SHORT_MAX_RST;
            cfg_reg.long_min_ms  <= LONG_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ms  <= cfg_data;
                REG_SHORT_MAX: cfg_reg.short_max_ms <= cfg_data;
                REG_LONG_MIN:  cfg_reg.long_min_ms  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pin_reg  <= pin_level;
            s1_tick_reg <= ms_tick;
        end
    end

    // step logic
    bdpc_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .pin_level  (s1_pin_reg),
        .ms_tick    (s1_tick_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // classifier state, updated as each word moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.filtered_sample <= LVL_RELEASED;
            state_reg.stable_level    <= LVL_RELEASED;
            state_reg.debounce_active <= 1'b0;
            state_reg.debounce_count  <= '0;
            state_reg.press_count     <= '0;
            state_reg.long_armed      <= 1'b0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stable_out    = out_reg.stable_out;
    assign press_event   = out_reg.press_event;
    assign release_event = out_reg.release_event;
    assign short_event   = out_reg.short_event;
    assign long_event    = out_reg.long_event;

`ifndef NO_ASSERTIONS
    // press and release never committed in the same word
    a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(press_event && release_event))
        else $error("press and release in one word");

    // a short press is always reported with its release
    a_short_with_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && short_event) |-> release_event)
        else $error("short event without release");

    // a press event leaves the stable level pressed
    a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && press_event) |-> (stable_out == LVL_PRESSED))
        else $error("press event with released level");

    // long detection is armed only while the button is held
    a_armed_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.long_armed |-> (state_reg.stable_level == LVL_PRESSED))
        else $error("long detector armed while released");
`endif

endmodule

// ===== dv/button_debounce_press_classifier_unit_tb.sv =====
// Self-checking testbench for the button debounce and press classifier unit.
module button_debounce_press_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    // Index with no register behind it, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    // Directed words, {pin_level, ms_tick}, first word at index 0.
    // Zero debounce, zero short max, zero long min: commit and long in one step.
    localparam logic [0:6][1:0] ZERO_TIME_WORDS = {
        2'b10, 2'b00, 2'b10, 2'b01, 2'b01, 2'b10, 2'b11
    };
    // Debounce 2, short max 3, long min 4: bounce back, press, long, release.
    localparam logic [0:13][1:0] BOUNCE_LONG_WORDS = {
        2'b01, 2'b11, 2'b11, 2'b11, 2'b00, 2'b01, 2'b01,
        2'b01, 2'b01, 2'b01, 2'b01, 2'b11, 2'b11, 2'b11
    };

    // Predicts the result word of every accepted word and checks arrivals
    class button_press_scoreboard;
        bit [CNT_W-1:0] settle_limit;
        bit [CNT_W-1:0] short_limit;
        bit [CNT_W-1:0] long_limit;
        bit             raw_last;
        bit             level;
        bit             change_pending;
        bit [CNT_W-1:0] settle_ticks;
        bit [CNT_W-1:0] held_ticks;
        bit             long_pending;
        bdpc_result_t   predicted_words[$];
        int             failures;

        function new();
            settle_limit   = DEBOUNCE_RST;
            short_limit    = SHORT_MAX_RST;
            long_limit     = LONG_MIN_RST;
            raw_last       = LVL_RELEASED;
            level          = LVL_RELEASED;
            change_pending = 1'b0;
            settle_ticks   = '0;
            held_ticks     = '0;
            long_pending   = 1'b0;
            failures       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
            case (idx)
                REG_DEBOUNCE:  settle_limit = value;
                REG_SHORT_MAX: short_limit  = value;
                REG_LONG_MIN:  long_limit   = value;
                default:       ;
            endcase
        endfunction

        // Advance the button state by one accepted word
        function void note_sample(logic pin, logic tick);
            bdpc_result_t want;
            bit           prev_level;
            want       = '0;
            prev_level = level;
            // counters stick at the top
            if (tick)
            begin
                if (settle_ticks != CNT_MAX) settle_ticks = settle_ticks + 1'b1;
                if (held_ticks != CNT_MAX) held_ticks = held_ticks + 1'b1;
            end
            // raw change restarts the settle count
            if (pin != raw_last)
            begin
                raw_last       = pin;
                change_pending = 1'b1;
                settle_ticks   = '0;
            end
            if (change_pending && settle_ticks >= settle_limit)
            begin
                level          = raw_last;
                change_pending = 1'b0;
            end
            // events from an edge of the debounced level
            if (level != prev_level)
            begin
                if (level == LVL_PRESSED)
                begin
                    want.press_event = 1'b1;
                    long_pending     = 1'b1;
                    held_ticks       = '0;
                end
                else
                begin
                    long_pending       = 1'b0;
                    want.short_event   = (held_ticks <= short_limit);
                    want.release_event = 1'b1;
                end
            end
            if (long_pending && held_ticks >= long_limit)
            begin
                want.long_event = 1'b1;
                long_pending    = 1'b0;
            end
            want.stable_out = level;
            predicted_words.push_back(want);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want)
            begin
                $error("%s: expected %0b, got %0b", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(bdpc_result_t got);
            bdpc_result_t want;
            if (predicted_words.size() == 0)
            begin
                $error("result word with none outstanding: %p", got);
                failures++;
            end
            else
            begin
                want = predicted_words.pop_front();
                compare_field("stable_out", want.stable_out, got.stable_out);
                compare_field("press_event", want.press_event, got.press_event);
                compare_field("release_event", want.release_event, got.release_event);
                compare_field("short_event", want.short_event, got.short_event);
                compare_field("long_event", want.long_event, got.long_event);
            end
        endfunction

        function int pending();
            return predicted_words.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CNT_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 pin_level = LVL_RELEASED;
    logic                 ms_tick = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 stable_out;
    logic                 press_event;
    logic                 release_event;
    logic                 short_event;
    logic                 long_event;

    button_press_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int cycles         = 0;

    button_debounce_press_classifier_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pin_level     (pin_level),
        .ms_tick       (ms_tick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stable_out    (stable_out),
        .press_event   (press_event),
        .release_event (release_event),
        .short_event   (short_event),
        .long_event    (long_event)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result word check
    always @(posedge clk)
    begin
        bdpc_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.stable_out    = stable_out;
            got.press_event   = press_event;
            got.release_event = release_event;
            got.short_event   = short_event;
            got.long_event    = long_event;
            sb.check_result(got);
        end
    end

    // Offer one word, with random idle cycles ahead of it; entered and left at negedge
    task automatic send_word(logic pin, logic tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        ms_tick   <= tick;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_sample(pin, tick);
        words_sent++;
        @(negedge clk);
    endtask

    // Hold off until every word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all registers back to back, plus one write to the unused index
    task automatic configure(logic [CNT_W-1:0] debounce, logic [CNT_W-1:0] short_max,
                             logic [CNT_W-1:0] long_min);
        logic [CNT_W-1:0] junk;
        junk = CNT_W'($urandom_range(CNT_MAX));
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= debounce;
        sb.write_reg(REG_DEBOUNCE, debounce);
        @(negedge clk);
        cfg_index <= REG_SHORT_MAX;
        cfg_data  <= short_max;
        sb.write_reg(REG_SHORT_MAX, short_max);
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        sb.write_reg(REG_UNUSED, junk);
        @(negedge clk);
        cfg_index <= REG_LONG_MIN;
        cfg_data  <= long_min;
        sb.write_reg(REG_LONG_MIN, long_min);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One button gesture: mostly bounce then a hold, sometimes pure noise
    task automatic send_gesture(logic hold_level, int span);
        int n;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
        begin
            n = $urandom_range(0, 3);
            repeat (n) send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
            n = $urandom_range(0, span);
            repeat (n) send_word(hold_level, $urandom_range(3) != 0);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] short_max;
        logic [CNT_W-1:0] long_min;
        int               span;
        int               budget;
        int               phase_end;
        logic             hold_level;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words
        send_idle_pct  = 20;
        recv_stall_pct = 74;
        configure('0, '0, '0);
        for (int i = 0; i < 7; i++)
            send_word(ZERO_TIME_WORDS[i][1], ZERO_TIME_WORDS[i][0]);
        wait_drained();
        configure(16'd2, 16'd3, 16'd4);
        for (int i = 0; i < 14; i++)
            send_word(BOUNCE_LONG_WORDS[i][1], BOUNCE_LONG_WORDS[i][0]);
        wait_drained();

        // Random gestures under several register settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    debounce  = CNT_W'($urandom_range(0, 4));
                    short_max = CNT_W'($urandom_range(0, 12));
                    long_min  = CNT_W'($urandom_range(0, 25));
                    span      = 30;
                    budget    = 110;
                end
                1:
                begin
                    debounce  = '0;
                    short_max = '0;
                    long_min  = '0;
                    span      = 6;
                    budget    = 100;
                end
                2:
                begin
                    debounce  = CNT_MAX;
                    short_max = CNT_MAX;
                    long_min  = CNT_MAX;
                    span      = 8;
                    budget    = 40;
                end
                3:
                begin
                    debounce  = 16'd1;
                    short_max = CNT_MAX;
                    long_min  = CNT_MAX;
                    span      = 12;
                    budget    = 100;
                end
                4:
                begin
                    debounce  = CNT_W'($urandom_range(0, 6));
                    short_max = CNT_W'($urandom_range(0, 20));
                    long_min  = CNT_W'($urandom_range(0, 40));
                    span      = 50;
                    budget    = 140;
                end
                default:
                begin
                    debounce  = 16'd3;
                    short_max = 16'd5;
                    long_min  = 16'd10;
                    span      = 20;
                    budget    = 110;
                end
            endcase
            if (p < 2)
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 74;
            end
            else if (p < 4)
            begin
                send_idle_pct  = 74;
                recv_stall_pct = 20;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            configure(debounce, short_max, long_min);
            phase_end  = words_sent + budget;
            hold_level = LVL_PRESSED;
            while (words_sent < phase_end)
            begin
                send_gesture(hold_level, span);
                hold_level = ~hold_level;
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
